// File: src/cnft_pkg.sv
package cnft_pkg;

	localparam int unsigned ADDR_W = 6;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_MINUTE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HOUR    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DAY     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MONTH   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WEEKDAY = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_SEARCH,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_LOAD,
		OP_TICK,
		OP_STEP
	} op_t;

	typedef struct packed {
		op_t  op;
		logic capture;
		logic found;
	} cmd_t;

	typedef struct packed {
		logic match;
		logic ok;
		logic limit;
	} status_t;

	typedef struct packed {
		logic [59:0] minute;
		logic [23:0] hour;
		logic [30:0] day;
		logic [11:0] month;
		logic [6:0]  weekday;
	} cfg_t;

endpackage

// File: src/cnft_regs.sv
module cnft_regs
	import cnft_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.minute  <= '1;
			cfg_q.hour    <= '1;
			cfg_q.day     <= '1;
			cfg_q.month   <= '1;
			cfg_q.weekday <= '1;
		end else if (wr_en) begin
			unique case (idx)
				REG_MINUTE:  cfg_q.minute  <= pwdata[59:0];
				REG_HOUR:    cfg_q.hour    <= pwdata[23:0];
				REG_DAY:     cfg_q.day     <= pwdata[30:0];
				REG_MONTH:   cfg_q.month   <= pwdata[11:0];
				REG_WEEKDAY: cfg_q.weekday <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MINUTE:  prdata = {4'd0, cfg_q.minute};
			REG_HOUR:    prdata = {40'd0, cfg_q.hour};
			REG_DAY:     prdata = {33'd0, cfg_q.day};
			REG_MONTH:   prdata = {52'd0, cfg_q.month};
			REG_WEEKDAY: prdata = {57'd0, cfg_q.weekday};
			default:     prdata = '0;
		endcase
	end

endmodule

// File: src/cnft_ctrl.sv
module cnft_ctrl
	import cnft_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start_valid,
	output logic    start_stall,
	output logic    next_valid,
	input  logic    next_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   found_q, found_d;
	logic   next_valid_q;
	logic   out_free;

	assign out_free   = !next_valid_q || !next_stall;
	assign next_valid = next_valid_q;

	always_comb begin
		state_d = state_q;
		found_d = found_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_valid) begin
					state_d = ST_TICK;
				end
			end
			ST_TICK: begin
				if (!st.ok) begin
					state_d = ST_DONE;
					found_d = 1'b0;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				priority if (st.limit) begin
					state_d = ST_DONE;
					found_d = 1'b0;
				end else if (st.match) begin
					state_d = ST_DONE;
					found_d = 1'b1;
				end else if (!st.ok) begin
					state_d = ST_DONE;
					found_d = 1'b0;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		start_stall = (state_q != ST_IDLE);
		cmd.op      = OP_NONE;
		cmd.capture = 1'b0;
		cmd.found   = found_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_valid) begin
					cmd.op = OP_LOAD;
				end
			end
			ST_TICK: cmd.op = OP_TICK;
			ST_SEARCH: begin
				if (!st.limit && !st.match) begin
					cmd.op = OP_STEP;
				end
			end
			ST_DONE: cmd.capture = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			found_q      <= 1'b0;
			next_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			found_q <= found_d;
			if (cmd.capture) begin
				next_valid_q <= 1'b1;
			end else if (!next_stall) begin
				next_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_to_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(start_valid && !start_stall) |=> (state_q == ST_TICK))
		else $error("accepted item did not start the minute advance");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && next_valid && next_stall) |=> (state_q == ST_DONE))
		else $error("result dropped while output was stalled");
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(next_valid) |-> ($past(state_q) == ST_DONE))
		else $error("output valid raised outside the done state");
`endif

endmodule

// File: src/cnft_dp.sv
module cnft_dp
	import cnft_pkg::*;
#(
	parameter int unsigned MAX_STEPS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output status_t     st,
	input  logic [11:0] start_year,
	input  logic [3:0]  start_month,
	input  logic [4:0]  start_day,
	input  logic [4:0]  start_hour,
	input  logic [5:0]  start_minute,
	input  logic [5:0]  start_second,
	input  logic [2:0]  start_weekday,
	output logic [11:0] next_year,
	output logic [3:0]  next_month,
	output logic [4:0]  next_day,
	output logic [4:0]  next_hour,
	output logic [5:0]  next_minute,
	output logic [2:0]  next_weekday,
	output logic        found
);

	localparam int unsigned SW = $clog2(MAX_STEPS + 1);

	function automatic logic is_leap(input logic [11:0] y);
		logic div100;
		div100 = 1'b0;
		for (int k = 0; k <= 40; k++) begin
			if (y == 12'(k * 100)) begin
				div100 = 1'b1;
			end
		end
		return (y[1:0] == 2'd0) && (!div100 || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [11:0] y, input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd2:                      len = is_leap(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [2:0] mod7(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		for (int k = 0; k < 5; k++) begin
			if (r >= 6'd7) begin
				r = r - 6'd7;
			end
		end
		return r[2:0];
	endfunction

	logic [11:0]   year_q;
	logic [3:0]    month_q;
	logic [4:0]    day_q;
	logic [4:0]    hour_q;
	logic [5:0]    minute_q;
	logic [2:0]    wd_q;
	logic [SW-1:0] step_q;

	logic [11:0] res_year_q;
	logic [3:0]  res_month_q;
	logic [4:0]  res_day_q;
	logic [4:0]  res_hour_q;
	logic [5:0]  res_minute_q;
	logic [2:0]  res_wd_q;
	logic        res_found_q;

	// load-time clamping
	logic [3:0] ld_month;
	logic [4:0] ld_len;
	logic [4:0] ld_day;

	// one search step
	logic [4:0] len;
	logic [3:0] month_idx;
	logic [4:0] day_idx;
	logic       month_hit, day_hit, hour_hit, minute_hit;
	logic       step, jump_m, jump_d, skip_h;
	logic       hour_carry, roll, do_date, date_ok;
	logic [2:0] wd_n;

	logic [11:0] year_d;
	logic [3:0]  month_d;
	logic [4:0]  day_d;
	logic [4:0]  hour_d;
	logic [5:0]  minute_d;
	logic [2:0]  wd_d;

	assign ld_month = (start_month == 4'd0) ? 4'd1 :
	                  (start_month > 4'd12) ? 4'd12 : start_month;
	assign ld_len   = month_len(start_year, ld_month);
	assign ld_day   = (start_day == 5'd0) ? 5'd1 :
	                  (start_day > ld_len) ? ld_len : start_day;

	assign len        = month_len(year_q, month_q);
	assign month_idx  = month_q - 4'd1;
	assign day_idx    = day_q - 5'd1;
	assign month_hit  = cfg.month[month_idx];
	assign day_hit    = cfg.day[day_idx] && cfg.weekday[wd_q];
	assign hour_hit   = cfg.hour[hour_q];
	assign minute_hit = cfg.minute[minute_q];

	assign step   = (cmd.op == OP_STEP);
	assign jump_m = step && !month_hit;
	assign jump_d = step && month_hit && !day_hit;
	assign skip_h = step && month_hit && day_hit && !hour_hit;

	// a skipped month ends its remaining days at once, so the weekday moves by all of them
	assign hour_carry = skip_h || (minute_q == 6'd59);
	assign roll       = jump_m || (day_q >= len);
	assign do_date    = jump_m || jump_d || (hour_carry && (hour_q == 5'd23));
	assign date_ok    = !(roll && (month_q == 4'd12) && (year_q == 12'd4095));
	assign wd_n       = jump_m ? mod7(6'(wd_q) + 6'(len) - 6'(day_q) + 6'd1) :
	                    ((wd_q == 3'd6) ? 3'd0 : wd_q + 3'd1);

	always_comb begin
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		wd_d     = wd_q;
		priority if (do_date) begin
			hour_d   = 5'd0;
			minute_d = 6'd0;
			wd_d     = wd_n;
			if (roll) begin
				day_d = 5'd1;
				if (month_q == 4'd12) begin
					month_d = 4'd1;
					year_d  = year_q + 12'd1;
				end else begin
					month_d = month_q + 4'd1;
				end
			end else begin
				day_d = day_q + 5'd1;
			end
		end else if (hour_carry) begin
			hour_d   = hour_q + 5'd1;
			minute_d = 6'd0;
		end else begin
			minute_d = minute_q + 6'd1;
		end
	end

	assign st.match = month_hit && day_hit && hour_hit && minute_hit;
	assign st.ok    = !do_date || date_ok;
	assign st.limit = (step_q >= SW'(MAX_STEPS));

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				year_q   <= start_year;
				month_q  <= ld_month;
				day_q    <= ld_day;
				hour_q   <= (start_hour > 5'd23) ? 5'd23 : start_hour;
				minute_q <= (start_minute > 6'd59) ? 6'd59 : start_minute;
				wd_q     <= (start_weekday == 3'd7) ? 3'd0 : start_weekday;
			end
			OP_TICK, OP_STEP: begin
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				wd_q     <= wd_d;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.op == OP_LOAD) begin
			step_q <= '0;
		end else if (step) begin
			step_q <= step_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_found_q  <= cmd.found;
			res_year_q   <= cmd.found ? year_q : 12'd0;
			res_month_q  <= cmd.found ? month_q : 4'd0;
			res_day_q    <= cmd.found ? day_q : 5'd0;
			res_hour_q   <= cmd.found ? hour_q : 5'd0;
			res_minute_q <= cmd.found ? minute_q : 6'd0;
			res_wd_q     <= cmd.found ? wd_q : 3'd0;
		end
	end

	// seconds never change the outcome: any value moves on to the next minute
	logic unused_second;
	assign unused_second = ^start_second;

	assign next_year    = res_year_q;
	assign next_month   = res_month_q;
	assign next_day     = res_day_q;
	assign next_hour    = res_hour_q;
	assign next_minute  = res_minute_q ^ {6{unused_second & 1'b0}};
	assign next_weekday = res_wd_q;
	assign found        = res_found_q;

`ifndef SYNTHESIS
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= SW'(MAX_STEPS))
		else $error("step counter ran past the limit");
	a_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_STEP) |-> (month_q >= 4'd1 && month_q <= 4'd12 &&
			day_q >= 5'd1 && day_q <= len && hour_q <= 5'd23 && minute_q <= 6'd59))
		else $error("working date out of range during search");
`endif

endmodule

// File: src/cron_next_fire_time.sv
// Finds the next minute that matches the minute, hour, day, month and weekday masks,
// starting from the minute after the given time. One item is taken at a time: the
// start fields are loaded, then the first minute advance is made, and the search then
// makes one check per cycle in the datapath's single step unit (a month miss, day
// miss, hour miss or minute miss each costs one check), up to MAX_STEPS checks; the
// result is registered in the done state that ends the search, later while the
// previous result still waits on next_stall. A search stopped by the check limit makes
// a further pass through the search state to see the limit. start_stall stays high
// from the transfer of a start item until its result is registered. found is 0, with
// all other result fields 0, when the check limit is reached or the search would pass
// 4095-12-31 23:59. The user must write the masks over the register port only while no
// search is running; the block itself has no check for this.
module cron_next_fire_time
	import cnft_pkg::*;
#(
	parameter int unsigned MAX_STEPS = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start_valid,
	output logic              start_stall,
	input  logic [11:0]       start_year,
	input  logic [3:0]        start_month,
	input  logic [4:0]        start_day,
	input  logic [4:0]        start_hour,
	input  logic [5:0]        start_minute,
	input  logic [5:0]        start_second,
	input  logic [2:0]        start_weekday,
	output logic              next_valid,
	input  logic              next_stall,
	output logic [11:0]       next_year,
	output logic [3:0]        next_month,
	output logic [4:0]        next_day,
	output logic [4:0]        next_hour,
	output logic [5:0]        next_minute,
	output logic [2:0]        next_weekday,
	output logic              found
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t st;

	cnft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cnft_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (start_valid),
		.start_stall (start_stall),
		.next_valid  (next_valid),
		.next_stall  (next_stall),
		.st          (st),
		.cmd         (cmd)
	);

	cnft_dp #(
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.st            (st),
		.start_year    (start_year),
		.start_month   (start_month),
		.start_day     (start_day),
		.start_hour    (start_hour),
		.start_minute  (start_minute),
		.start_second  (start_second),
		.start_weekday (start_weekday),
		.next_year     (next_year),
		.next_month    (next_month),
		.next_day      (next_day),
		.next_hour     (next_hour),
		.next_minute   (next_minute),
		.next_weekday  (next_weekday),
		.found         (found)
	);

endmodule
